### rtl/rational_arith_reduce_top_defines.svh
// Assertion macros for the rational arithmetic reduction block.
// Used by the port checker only; depends on nothing else.
`ifndef RATIONAL_ARITH_REDUCE_TOP_DEFINES_SVH
`define RATIONAL_ARITH_REDUCE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define RAR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rar check failed: %m");

// Next-cycle implication, disabled while reset is high.
`define RAR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rar check failed: %m");

`endif

### rtl/rar_pkg.sv
// Shared types, constants and the microcode table of the rational reducer.
// No dependencies; imported by every module of the block.
package rar_pkg;

   localparam int OPERAND_W_DEF = 32;
   localparam int IN_W          = 32;
   localparam int OP_W          = 2;
   localparam int RES_NUM_W     = 64;
   localparam int RES_DEN_W     = 63;
   localparam int STAT_W        = 2;
   localparam int PC_W          = 4;

   typedef enum logic [OP_W-1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK       = 2'd0,
      STAT_ZERO_DEN = 2'd1,
      STAT_DIV_ZERO = 2'd2
   } stat_type;

   // datapath micro-operations
   typedef enum logic [3:0] {
      UOP_MUL1,
      UOP_MUL2,
      UOP_MUL3,
      UOP_COMBINE,
      UOP_GCD_LOAD,
      UOP_STRIP_BOTH,
      UOP_STRIP_U,
      UOP_STRIP_V,
      UOP_GCD_SUB,
      UOP_GCD_FIX,
      UOP_DIV_X,
      UOP_DIV_CLR,
      UOP_DIV_Y,
      UOP_OUT
   } uop_type;

   // jump conditions
   typedef enum logic [3:0] {
      COND_NONE,
      COND_ERR,
      COND_X_ZERO,
      COND_BOTH_EVEN,
      COND_U_EVEN,
      COND_V_EVEN,
      COND_UV_NE,
      COND_CNT_MORE,
      COND_OUT_BUSY
   } cond_type;

   typedef struct packed {
      uop_type           uop;
      cond_type          cond;
      logic [PC_W-1:0]   target;
   } ucode_type;

   typedef struct packed {
      logic err;
      logic x_zero;
      logic both_even;
      logic u_even;
      logic v_even;
      logic uv_ne;
      logic cnt_more;
   } dp_flags_type;

   typedef struct packed {
      logic busy;
      logic fire;
   } seq_state_type;

   // step addresses that are jump targets
   localparam logic [PC_W-1:0] PC_STRIP_BOTH = 4'd5;
   localparam logic [PC_W-1:0] PC_STRIP_U    = 4'd6;
   localparam logic [PC_W-1:0] PC_STRIP_V    = 4'd7;
   localparam logic [PC_W-1:0] PC_DIV_X      = 4'd10;
   localparam logic [PC_W-1:0] PC_DIV_Y      = 4'd12;
   localparam logic [PC_W-1:0] PC_OUT        = 4'd13;

   // The program: one control word per step. A taken condition jumps to
   // the target, otherwise the step counter advances.
   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      unique case (pc)
         4'd0:    w = '{UOP_MUL1,       COND_ERR,       PC_OUT};
         4'd1:    w = '{UOP_MUL2,       COND_NONE,      PC_OUT};
         4'd2:    w = '{UOP_MUL3,       COND_NONE,      PC_OUT};
         4'd3:    w = '{UOP_COMBINE,    COND_NONE,      PC_OUT};
         4'd4:    w = '{UOP_GCD_LOAD,   COND_X_ZERO,    PC_OUT};
         4'd5:    w = '{UOP_STRIP_BOTH, COND_BOTH_EVEN, PC_STRIP_BOTH};
         4'd6:    w = '{UOP_STRIP_U,    COND_U_EVEN,    PC_STRIP_U};
         4'd7:    w = '{UOP_STRIP_V,    COND_V_EVEN,    PC_STRIP_V};
         4'd8:    w = '{UOP_GCD_SUB,    COND_UV_NE,     PC_STRIP_V};
         4'd9:    w = '{UOP_GCD_FIX,    COND_NONE,      PC_OUT};
         4'd10:   w = '{UOP_DIV_X,      COND_CNT_MORE,  PC_DIV_X};
         4'd11:   w = '{UOP_DIV_CLR,    COND_NONE,      PC_OUT};
         4'd12:   w = '{UOP_DIV_Y,      COND_CNT_MORE,  PC_DIV_Y};
         default: w = '{UOP_OUT,        COND_OUT_BUSY,  PC_OUT};
      endcase
      return w;
   endfunction

endpackage

### rtl/rar_seq.sv
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on rar_pkg.
module rar_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   out_busy,
   input  rar_pkg::dp_flags_type  flags,
   output rar_pkg::ucode_type     ctrl,
   output rar_pkg::seq_state_type seq_state
);
   import rar_pkg::*;

   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;
   logic            busy_ff;
   logic            busy_in;
   logic            take;
   logic            fire;

   always_comb begin
      ctrl = ucode_rom(pc_ff);
   end

   always_comb begin
      unique case (ctrl.cond)
         COND_NONE:      take = 1'b0;
         COND_ERR:       take = flags.err;
         COND_X_ZERO:    take = flags.x_zero;
         COND_BOTH_EVEN: take = flags.both_even;
         COND_U_EVEN:    take = flags.u_even;
         COND_V_EVEN:    take = flags.v_even;
         COND_UV_NE:     take = flags.uv_ne;
         COND_CNT_MORE:  take = flags.cnt_more;
         COND_OUT_BUSY:  take = out_busy;
         default:        take = 1'b0;
      endcase
   end

   // the output step retires the word once the result register is free
   assign fire = busy_ff && (ctrl.uop == UOP_OUT) && !out_busy;

   always_comb begin
      pc_in   = pc_ff;
      busy_in = busy_ff;
      priority if (!busy_ff) begin
         busy_in = start;
         pc_in   = '0;
      end else if (fire) begin
         busy_in = 1'b0;
         pc_in   = '0;
      end else if (take) begin
         pc_in = ctrl.target;
      end else begin
         pc_in = pc_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= '0;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
      end
   end

   assign seq_state.busy = busy_ff;
   assign seq_state.fire = fire;

endmodule

### rtl/rar_dp.sv
// Datapath: operand registers, shared multiplier, subtractor pair,
// binary GCD and restoring divider registers. Depends on rar_pkg.
module rar_dp #(
   parameter int OPERAND_WIDTH = rar_pkg::OPERAND_W_DEF
) (
   input  logic                          clock,
   input  logic                          start,
   input  logic                          exec,
   input  rar_pkg::uop_type              uop,
   input  logic [rar_pkg::OP_W-1:0]      op,
   input  logic [rar_pkg::IN_W-1:0]      a_num,
   input  logic [rar_pkg::IN_W-1:0]      a_den,
   input  logic [rar_pkg::IN_W-1:0]      b_num,
   input  logic [rar_pkg::IN_W-1:0]      b_den,
   output rar_pkg::dp_flags_type         flags,
   output logic [rar_pkg::RES_NUM_W-1:0] res_num,
   output logic [rar_pkg::RES_DEN_W-1:0] res_den,
   output logic [rar_pkg::STAT_W-1:0]    status
);
   import rar_pkg::*;

   localparam int W     = OPERAND_WIDTH;
   localparam int PW    = 2 * OPERAND_WIDTH;
   localparam int CNT_W = $clog2(PW);

   // {sign, magnitude}; the most negative value keeps its own bits
   function automatic logic [W:0] split_operand(input logic [IN_W-1:0] raw);
      logic [W-1:0] x;
      logic         neg;
      x   = raw[W-1:0];
      neg = x[W-1];
      return {neg, (neg ? W'(~x + 1'b1) : x)};
   endfunction

   logic [W:0]        a_n_sp, a_d_sp, b_n_sp, b_d_sp;
   logic              a_neg, b_neg;
   stat_type          stat_cap;

   logic [W-1:0]      an_ff, ad_ff, bn_ff, bd_ff;
   logic [W-1:0]      an_in, ad_in, bn_in, bd_in;
   op_type            op_ff, op_in;
   logic              a_neg_ff, a_neg_in, b_neg_ff, b_neg_in;
   logic              neg_ff, neg_in;
   stat_type          stat_ff, stat_in;
   logic [PW-1:0]     x_ff, x_in, y_ff, y_in, u_ff, u_in, v_ff, v_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   logic [W-1:0]      mul_a, mul_b;
   logic [PW-1:0]     prod;
   logic [PW-1:0]     s_a, s_b, s_sum;
   logic [PW:0]       d_ab, d_ba;
   logic              qn;
   logic [PW-1:0]     div_src;
   logic [PW:0]       rem_sh;
   logic [PW+1:0]     trial;
   logic              qbit;
   logic [PW-1:0]     rem_next, quo_next;
   logic [RES_NUM_W-1:0] num_ext, den_ext;

   // capture-side decode
   always_comb begin
      a_n_sp = split_operand(a_num);
      a_d_sp = split_operand(a_den);
      b_n_sp = split_operand(b_num);
      b_d_sp = split_operand(b_den);
      a_neg  = (a_n_sp[W-1:0] != '0) && (a_n_sp[W] != a_d_sp[W]);
      b_neg  = (b_n_sp[W-1:0] != '0) && (b_n_sp[W] != b_d_sp[W]);
      priority if ((a_d_sp[W-1:0] == '0) || (b_d_sp[W-1:0] == '0)) begin
         stat_cap = STAT_ZERO_DEN;
      end else if ((op_type'(op) == OP_DIV) && (b_n_sp[W-1:0] == '0)) begin
         stat_cap = STAT_DIV_ZERO;
      end else begin
         stat_cap = STAT_OK;
      end
   end

   // shared multiplier
   always_comb begin
      unique case (uop)
         UOP_MUL1: begin
            mul_a = an_ff;
            mul_b = (op_ff == OP_MUL) ? bn_ff : bd_ff;
         end
         UOP_MUL2: begin
            mul_a = ad_ff;
            mul_b = (op_ff == OP_DIV) ? bn_ff : bd_ff;
         end
         default: begin
            mul_a = bn_ff;
            mul_b = ad_ff;
         end
      endcase
      prod = PW'(mul_a) * PW'(mul_b);
   end

   // subtractor pair, shared by the signed combine and the GCD step
   always_comb begin
      s_a   = (uop == UOP_COMBINE) ? x_ff : u_ff;
      s_b   = v_ff;
      s_sum = s_a + s_b;
      d_ab  = {1'b0, s_a} - {1'b0, s_b};
      d_ba  = {1'b0, s_b} - {1'b0, s_a};
      qn    = (op_ff == OP_SUB) ? !b_neg_ff : b_neg_ff;
   end

   // one restoring division step; V holds the partial remainder, U the GCD
   always_comb begin
      div_src  = (uop == UOP_DIV_Y) ? y_ff : x_ff;
      rem_sh   = {v_ff, div_src[PW-1]};
      trial    = {1'b0, rem_sh} - {2'b00, u_ff};
      qbit     = !trial[PW+1];
      rem_next = qbit ? trial[PW-1:0] : rem_sh[PW-1:0];
      quo_next = {div_src[PW-2:0], qbit};
   end

   always_comb begin
      an_in    = an_ff;
      ad_in    = ad_ff;
      bn_in    = bn_ff;
      bd_in    = bd_ff;
      op_in    = op_ff;
      a_neg_in = a_neg_ff;
      b_neg_in = b_neg_ff;
      neg_in   = neg_ff;
      stat_in  = stat_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      u_in     = u_ff;
      v_in     = v_ff;
      cnt_in   = cnt_ff;
      if (start) begin
         an_in    = a_n_sp[W-1:0];
         ad_in    = a_d_sp[W-1:0];
         bn_in    = b_n_sp[W-1:0];
         bd_in    = b_d_sp[W-1:0];
         op_in    = op_type'(op);
         a_neg_in = a_neg;
         b_neg_in = b_neg;
         neg_in   = a_neg ^ b_neg;
         stat_in  = stat_cap;
      end else if (exec) begin
         unique case (uop)
            UOP_MUL1: x_in = prod;
            UOP_MUL2: y_in = prod;
            UOP_MUL3: v_in = prod;
            UOP_COMBINE: begin
               if ((op_ff == OP_ADD) || (op_ff == OP_SUB)) begin
                  priority if (a_neg_ff == qn) begin
                     x_in   = s_sum;
                     neg_in = a_neg_ff;
                  end else if (!d_ab[PW]) begin
                     x_in   = d_ab[PW-1:0];
                     neg_in = a_neg_ff;
                  end else begin
                     x_in   = d_ba[PW-1:0];
                     neg_in = qn;
                  end
               end
            end
            UOP_GCD_LOAD: begin
               u_in   = x_ff;
               v_in   = y_ff;
               cnt_in = '0;
            end
            UOP_STRIP_BOTH: begin
               if (!u_ff[0] && !v_ff[0]) begin
                  u_in   = u_ff >> 1;
                  v_in   = v_ff >> 1;
                  cnt_in = cnt_ff + 1'b1;
               end
            end
            UOP_STRIP_U: begin
               if (!u_ff[0]) begin
                  u_in = u_ff >> 1;
               end
            end
            UOP_STRIP_V: begin
               if (!v_ff[0]) begin
                  v_in = v_ff >> 1;
               end
            end
            UOP_GCD_SUB: begin
               if (d_ab[PW]) begin
                  v_in = d_ba[PW-1:0];
               end else begin
                  u_in = v_ff;
                  v_in = d_ab[PW-1:0];
               end
            end
            UOP_GCD_FIX: begin
               u_in   = u_ff << cnt_ff;
               v_in   = '0;
               cnt_in = '0;
            end
            UOP_DIV_X: begin
               x_in   = quo_next;
               v_in   = rem_next;
               cnt_in = cnt_ff + 1'b1;
            end
            UOP_DIV_CLR: begin
               v_in   = '0;
               cnt_in = '0;
            end
            UOP_DIV_Y: begin
               y_in   = quo_next;
               v_in   = rem_next;
               cnt_in = cnt_ff + 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      an_ff    <= an_in;
      ad_ff    <= ad_in;
      bn_ff    <= bn_in;
      bd_ff    <= bd_in;
      op_ff    <= op_in;
      a_neg_ff <= a_neg_in;
      b_neg_ff <= b_neg_in;
      neg_ff   <= neg_in;
      stat_ff  <= stat_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      u_ff     <= u_in;
      v_ff     <= v_in;
      cnt_ff   <= cnt_in;
   end

   always_comb begin
      flags.err       = (stat_ff != STAT_OK);
      flags.x_zero    = (x_ff == '0);
      flags.both_even = !u_ff[0] && !v_ff[0];
      flags.u_even    = !u_ff[0];
      flags.v_even    = !v_ff[0];
      flags.uv_ne     = (u_ff != v_ff);
      flags.cnt_more  = (cnt_ff != CNT_W'(PW - 1));
   end

   // result fields; a zero numerator reads as 0/1, an error as 0/0
   always_comb begin
      num_ext = RES_NUM_W'(x_ff);
      den_ext = (x_ff == '0) ? RES_NUM_W'(1) : RES_NUM_W'(y_ff);
      if (stat_ff != STAT_OK) begin
         res_num = '0;
         res_den = '0;
      end else begin
         res_num = neg_ff ? (~num_ext + 1'b1) : num_ext;
         res_den = den_ext[RES_DEN_W-1:0];
      end
      status = stat_ff;
   end

endmodule

### rtl/rational_arith_reduce_top.sv
// Top level of the rational arithmetic reducer: handshakes, result register.
// Depends on rar_pkg, rar_seq and rar_dp.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------------
//   req     | in        | req_valid/req_stall| req_op, req_a_num/den, req_b_num/den
//   rsp     | out       | rsp_valid/rsp_stall| rsp_res_num, rsp_res_den, rsp_status
//
// One word at a time. A word holds the sequencer through the products, GCD set-up,
// the GCD subtractions and the stripping of factors of two, the GCD fix-up, two
// exact divisions and the output step. An erroneous word jumps to the output step
// from the first product step, a word with a zero numerator from the GCD set-up.
// Synchronous active-high reset idles the sequencer and empties the result
// register; rsp_stall holds the result and the next word may still be taken.
module rational_arith_reduce_top #(
   parameter int OPERAND_WIDTH = rar_pkg::OPERAND_W_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [rar_pkg::OP_W-1:0]      req_op,
   input  logic [rar_pkg::IN_W-1:0]      req_a_num,
   input  logic [rar_pkg::IN_W-1:0]      req_a_den,
   input  logic [rar_pkg::IN_W-1:0]      req_b_num,
   input  logic [rar_pkg::IN_W-1:0]      req_b_den,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [rar_pkg::RES_NUM_W-1:0] rsp_res_num,
   output logic [rar_pkg::RES_DEN_W-1:0] rsp_res_den,
   output logic [rar_pkg::STAT_W-1:0]    rsp_status
);
   import rar_pkg::*;

   ucode_type              ctrl;
   dp_flags_type           flags;
   seq_state_type          seq_state;
   logic                   start;
   logic                   out_busy;
   logic [RES_NUM_W-1:0]   dp_num;
   logic [RES_DEN_W-1:0]   dp_den;
   logic [STAT_W-1:0]      dp_status;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RES_NUM_W-1:0]   res_num_ff, res_num_in;
   logic [RES_DEN_W-1:0]   res_den_ff, res_den_in;
   logic [STAT_W-1:0]      status_ff, status_in;

   // take a word whenever the sequencer is idle
   assign req_stall = seq_state.busy;
   assign start     = req_valid && !seq_state.busy;

   // the result register is occupied while a word waits under stall
   assign out_busy  = rsp_valid_ff && rsp_stall;

   rar_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .out_busy  (out_busy),
      .flags     (flags),
      .ctrl      (ctrl),
      .seq_state (seq_state)
   );

   rar_dp #(
      .OPERAND_WIDTH (OPERAND_WIDTH)
   ) u_dp (
      .clock   (clock),
      .start   (start),
      .exec    (seq_state.busy),
      .uop     (ctrl.uop),
      .op      (req_op),
      .a_num   (req_a_num),
      .a_den   (req_a_den),
      .b_num   (req_b_num),
      .b_den   (req_b_den),
      .flags   (flags),
      .res_num (dp_num),
      .res_den (dp_den),
      .status  (dp_status)
   );

   // load the result register on the output step, drop valid once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      res_num_in   = res_num_ff;
      res_den_in   = res_den_ff;
      status_in    = status_ff;
      priority if (seq_state.fire) begin
         rsp_valid_in = 1'b1;
         res_num_in   = dp_num;
         res_den_in   = dp_den;
         status_in    = dp_status;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_num_ff <= res_num_in;
      res_den_ff <= res_den_in;
      status_ff  <= status_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_res_num = res_num_ff;
   assign rsp_res_den = res_den_ff;
   assign rsp_status  = status_ff;

endmodule

### rtl/rar_check.sv
// Port-level checker for the rational reducer, bound to the top level.
// Depends on rar_pkg and rational_arith_reduce_top_defines.svh.
`include "rational_arith_reduce_top_defines.svh"

module rar_check (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic [rar_pkg::OP_W-1:0]      req_op,
   input logic [rar_pkg::IN_W-1:0]      req_a_num,
   input logic [rar_pkg::IN_W-1:0]      req_a_den,
   input logic [rar_pkg::IN_W-1:0]      req_b_num,
   input logic [rar_pkg::IN_W-1:0]      req_b_den,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [rar_pkg::RES_NUM_W-1:0] rsp_res_num,
   input logic [rar_pkg::RES_DEN_W-1:0] rsp_res_den,
   input logic [rar_pkg::STAT_W-1:0]    rsp_status
);
   import rar_pkg::*;

   // a stalled result word holds
   `RAR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_res_num) && $stable(rsp_res_den) && $stable(rsp_status))

   // an accepted word blocks the input channel in the next cycle
   `RAR_ASSERT_NEXT(a_busy_after_take, clock, reset, req_valid && !req_stall, req_stall)

   // an error word carries an all-zero fraction
   `RAR_ASSERT_NOW(a_err_zero, clock, reset, rsp_valid && (rsp_status == STAT_ZERO_DEN || rsp_status == STAT_DIV_ZERO), rsp_res_num == '0 && rsp_res_den == '0)

   // a good word never carries a zero denominator
   `RAR_ASSERT_NOW(a_ok_den, clock, reset, rsp_valid && rsp_status == STAT_OK, rsp_res_den != '0)

endmodule

bind rational_arith_reduce_top rar_check u_rar_check (.*);

### sim/testbench.sv
// Self-checking bench for rational_arith_reduce_top: directed table, then random words.
// Depends on rar_pkg and the RTL of the block; reads nothing else.
module testbench;
   import rar_pkg::*;

   localparam int unsigned RANDOM_WORDS = 1800;
   localparam int unsigned CYCLE_LIMIT  = 4_000_000;
   localparam int unsigned DRAIN_CYCLES = 500;

   // One reduced fraction as the block returns it.
   typedef struct packed {
      logic [RES_NUM_W-1:0] num;
      logic [RES_DEN_W-1:0] den;
      stat_type             status;
   } fraction_type;

   // One stimulus word; typed rows carry a hand-worked expected fraction.
   typedef struct packed {
      op_type          op;
      logic [IN_W-1:0] a_num;
      logic [IN_W-1:0] a_den;
      logic [IN_W-1:0] b_num;
      logic [IN_W-1:0] b_den;
      logic            typed;
      fraction_type    want;
   } stim_row_type;

   localparam fraction_type NO_WANT = '{64'd0, 63'd0, STAT_OK};

   // Directed rows: extremes, every operation, every error and the zero result.
   localparam int DIRECTED_ROWS = 22;
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      // 1/1 + 1/1 = 2/1
      '{OP_ADD, 32'd1, 32'd1, 32'd1, 32'd1, 1'b1, '{64'd2, 63'd1, STAT_OK}},
      // 2/4 + 0/1: the reduction a downward divisor search would skip
      '{OP_ADD, 32'd2, 32'd4, 32'd0, 32'd1, 1'b1, '{64'd1, 63'd2, STAT_OK}},
      // equal fractions cancel to 0/1
      '{OP_SUB, 32'd3, 32'd7, 32'd3, 32'd7, 1'b1, '{64'd0, 63'd1, STAT_OK}},
      '{OP_MUL, 32'd0, 32'd5, 32'd9, 32'd4, 1'b1, '{64'd0, 63'd1, STAT_OK}},
      // division by a zero fraction
      '{OP_DIV, 32'd5, 32'd3, 32'd0, 32'd7, 1'b1, '{64'd0, 63'd0, STAT_DIV_ZERO}},
      // zero input denominator
      '{OP_ADD, 32'd1, 32'd0, 32'd1, 32'd1, 1'b1, '{64'd0, 63'd0, STAT_ZERO_DEN}},
      // zero denominator wins over the divide-by-zero check
      '{OP_DIV, 32'd1, 32'd1, 32'd0, 32'd0, 1'b1, '{64'd0, 63'd0, STAT_ZERO_DEN}},
      '{OP_DIV, 32'd1, 32'd2, 32'd3, 32'd4, 1'b1, '{64'd2, 63'd3, STAT_OK}},
      // most negative operands
      '{OP_MUL, 32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1, 1'b1,
        '{64'h4000_0000_0000_0000, 63'd1, STAT_OK}},
      '{OP_MUL, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'd1, 1'b0, NO_WANT},
      '{OP_ADD, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'd1, 1'b1,
        '{64'h0000_0000_FFFF_FFFE, 63'd1, STAT_OK}},
      '{OP_SUB, 32'h8000_0000, 32'd1, 32'h7FFF_FFFF, 32'd1, 1'b1,
        '{64'hFFFF_FFFF_0000_0001, 63'd1, STAT_OK}},
      '{OP_DIV, 32'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1, 1'b0, NO_WANT},
      '{OP_ADD, 32'd1, 32'h8000_0000, 32'd1, 32'h7FFF_FFFF, 1'b0, NO_WANT},
      // sign carried by the denominator moves to the numerator
      '{OP_MUL, 32'd6, 32'hFFFF_FFFC, 32'd1, 32'd1, 1'b1,
        '{64'hFFFF_FFFF_FFFF_FFFD, 63'd2, STAT_OK}},
      '{OP_DIV, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 1'b1,
        '{64'hFFFF_FFFF_FFFF_FFFF, 63'd1, STAT_OK}},
      '{OP_SUB, 32'd1, 32'd2, 32'd1, 32'd3, 1'b1, '{64'd1, 63'd6, STAT_OK}},
      '{OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b0, NO_WANT},
      '{OP_DIV, 32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1, 1'b1, '{64'd1, 63'd1, STAT_OK}},
      '{OP_MUL, 32'd1, 32'h8000_0000, 32'd1, 32'h8000_0000, 1'b1,
        '{64'd1, 63'h4000_0000_0000_0000, STAT_OK}},
      '{OP_DIV, 32'd0, 32'hFFFF_FFFB, 32'd3, 32'd1, 1'b1, '{64'd0, 63'd1, STAT_OK}},
      '{OP_SUB, 32'h1234_5678, 32'h09AB_CDEF, 32'h0FED_CBA9, 32'h7654_3210, 1'b0, NO_WANT}
   };

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [OP_W-1:0]      req_op;
   logic [IN_W-1:0]      req_a_num;
   logic [IN_W-1:0]      req_a_den;
   logic [IN_W-1:0]      req_b_num;
   logic [IN_W-1:0]      req_b_den;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [RES_NUM_W-1:0] rsp_res_num;
   logic [RES_DEN_W-1:0] rsp_res_den;
   logic [STAT_W-1:0]    rsp_status;

   fraction_type pending_results[$];
   int unsigned  failures   = 0;
   int unsigned  stall_left = 0;
   bit           quiet      = 1'b0;   // set: no gaps and no stalls on either side

   rational_arith_reduce_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_op      (req_op),
      .req_a_num   (req_a_num),
      .req_a_den   (req_a_den),
      .req_b_num   (req_b_num),
      .req_b_den   (req_b_den),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_res_num (rsp_res_num),
      .rsp_res_den (rsp_res_den),
      .rsp_status  (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Magnitude of a two's complement operand; the most negative value maps to 2^31.
   function automatic logic [63:0] magnitude(input logic [IN_W-1:0] x);
      return x[IN_W-1] ? (64'h1_0000_0000 - {32'd0, x}) : {32'd0, x};
   endfunction

   // Cross-multiply, then divide numerator and denominator by their GCD.
   function automatic fraction_type reduce_fraction(input op_type op,
                                                    input logic [IN_W-1:0] an,
                                                    input logic [IN_W-1:0] ad,
                                                    input logic [IN_W-1:0] bn,
                                                    input logic [IN_W-1:0] bd);
      logic [63:0]  anm, adm, bnm, bdm, p, q, num, den, u, v, t;
      logic         a_neg, b_neg, q_neg, neg;
      fraction_type r;
      anm = magnitude(an);
      adm = magnitude(ad);
      bnm = magnitude(bn);
      bdm = magnitude(bd);
      r   = NO_WANT;
      if (adm == 0 || bdm == 0) begin
         r.status = STAT_ZERO_DEN;
         return r;
      end
      if (op == OP_DIV && bnm == 0) begin
         r.status = STAT_DIV_ZERO;
         return r;
      end
      a_neg = (anm != 0) && (an[IN_W-1] != ad[IN_W-1]);
      b_neg = (bnm != 0) && (bn[IN_W-1] != bd[IN_W-1]);
      unique case (op)
         OP_MUL: begin
            num = anm * bnm;
            den = adm * bdm;
            neg = a_neg ^ b_neg;
         end
         OP_DIV: begin
            num = anm * bdm;
            den = adm * bnm;
            neg = a_neg ^ b_neg;
         end
         default: begin
            // add or subtract on sign and magnitude
            p     = anm * bdm;
            q     = bnm * adm;
            q_neg = (op == OP_SUB) ? !b_neg : b_neg;
            den   = adm * bdm;
            if (a_neg == q_neg) begin
               num = p + q;
               neg = a_neg;
            end else if (p >= q) begin
               num = p - q;
               neg = a_neg;
            end else begin
               num = q - p;
               neg = q_neg;
            end
         end
      endcase
      if (num == 0) begin
         r.den = 63'd1;
         return r;
      end
      u = num;
      v = den;
      while (v != 0) begin
         t = u % v;
         u = v;
         v = t;
      end
      num   = num / u;
      den   = den / u;
      r.num = neg ? (64'd0 - num) : num;
      r.den = den[RES_DEN_W-1:0];
      return r;
   endfunction

   // Idle length: mostly none, some short, a few long.
   function automatic int unsigned pick_gap();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (quiet || sel < 60) return 0;
      if (sel < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Operand mix: full-width noise, small values that reduce a lot,
   // sign-extended mid-width values and the boundary values.
   function automatic logic [IN_W-1:0] pick_operand();
      int unsigned     sel;
      logic [IN_W-1:0] r;
      sel = $urandom_range(0, 99);
      r   = $urandom;
      if (sel < 55) return r;
      if (sel < 80) return IN_W'($urandom_range(0, 40)) - 32'd20;
      if (sel < 92) return IN_W'($signed(r) >>> $urandom_range(1, 30));
      case ($urandom_range(0, 4))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'hFFFF_FFFF;
         3:       return 32'd1;
         default: return 32'd0;
      endcase
   endfunction

   task automatic flag_failure(input string what, input fraction_type want,
                               input fraction_type got);
      failures++;
      if (failures <= 10)
         $display("mismatch (%0s) at %0t: expected %h / %h status %0d, got %h / %h status %0d",
                  what, $realtime, want.num, want.den, want.status,
                  got.num, got.den, got.status);
   endtask

   // Present one word at the falling edge and hold it until taken; then
   // queue its expected fraction.
   task automatic send_word(input stim_row_type w);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_op    <= w.op;
      req_a_num <= w.a_num;
      req_a_den <= w.a_den;
      req_b_num <= w.b_num;
      req_b_den <= w.b_den;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(w.typed ? w.want
                                : reduce_fraction(w.op, w.a_num, w.a_den, w.b_num, w.b_den));
   endtask

   // Receiver back-pressure, changed at the falling edge only.
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= pick_gap();
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Sample each result word at the rising edge and compare with the oldest expectation.
   always @(posedge clock) begin
      fraction_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_res_num, rsp_res_den, stat_type'(rsp_status)};
         if (pending_results.size() == 0) begin
            flag_failure("unexpected word", NO_WANT, got);
         end else begin
            want = pending_results.pop_front();
            if (got.num !== want.num || got.den !== want.den || got.status !== want.status)
               flag_failure("field", want, got);
         end
      end
   end

   // Watchdog: end a hung run.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("testbench: errors");
      $finish;
   end

   initial begin
      stim_row_type w;
      req_valid = 1'b0;
      req_op    = OP_ADD;
      req_a_num = '0;
      req_a_den = '0;
      req_b_num = '0;
      req_b_den = '0;
      reset     = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: walk the table.
      for (int i = 0; i < DIRECTED_ROWS; i++)
         send_word(DIRECTED[i]);

      // Random part: mostly rich operands, a few equal fractions and
      // forced zero denominators; flip in and out of quiet stretches.
      for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
         if ($urandom_range(0, 99) == 0) quiet = !quiet;
         w.op    = op_type'($urandom_range(0, 3));
         w.a_num = pick_operand();
         w.a_den = pick_operand();
         w.b_num = pick_operand();
         w.b_den = pick_operand();
         if ($urandom_range(0, 99) < 4) begin
            w.b_num = w.a_num;
            w.b_den = w.a_den;
         end
         if ($urandom_range(0, 99) < 2) begin
            if ($urandom_range(0, 1) == 0) w.a_den = '0;
            else                           w.b_den = '0;
         end
         w.typed = 1'b0;
         w.want  = NO_WANT;
         send_word(w);
      end
      @(negedge clock);
      req_valid <= 1'b0;

      // Drain: wait for every expected word, then watch for strays.
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (failures == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule
